@@ rtl/tfp_pkg.sv @@
package tfp_pkg;

  // Field type codes
  localparam logic [1:0] FT_INT32 = 2'd0;
  localparam logic [1:0] FT_INT64 = 2'd1;
  localparam logic [1:0] FT_BOOL  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_FIELD_TYPE = 1'b0;
  localparam logic CFG_TRIM       = 1'b1;

  localparam int CFG_DATA_W = 2;

  // Integer range limits
  localparam logic [63:0] LIMIT32     = 64'd2147483648;
  localparam logic [63:0] MAX32       = 64'd2147483647;
  localparam logic [63:0] LIMIT64     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT64_D10 = 64'd922337203685477580;

  // Content length saturation point
  localparam logic [2:0] LEN_SAT = 3'd6;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_cell;
  } tfp_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               is_valid;
  } tfp_out_t;

  // Classified word held in the queue
  typedef struct packed {
    logic [7:0] lc;
    logic       blank;
    logic       digit;
    logic [3:0] dval;
    logic       minus;
    logic       plus;
    logic       last;
    logic       empty;
  } tfp_cls_t;

  // Per-cell parse state
  typedef struct packed {
    logic        failed;
    logic        negative;
    logic        digit_seen;
    logic [63:0] acc;
    logic [2:0]  len;
    logic        true_match;
    logic        false_match;
    logic        bit_value;
  } tfp_cell_t;

  localparam tfp_cell_t CELL_CLEAR = '{
    failed: 1'b0, negative: 1'b0, digit_seen: 1'b0, acc: 64'd0, len: 3'd0,
    true_match: 1'b1, false_match: 1'b1, bit_value: 1'b0
  };

  // Letters of the boolean words, lower case
  function automatic logic [7:0] true_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h74;
      2'd1:    c = 8'h72;
      2'd2:    c = 8'h75;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] false_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h6C;
      3'd3:    c = 8'h73;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/tfp_front.sv @@
module tfp_front import tfp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tfp_in_t  in_word,
  output logic     q_valid,
  output tfp_cls_t q_item,
  input  logic     q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tfp_cls_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  tfp_cls_t             cls;
  logic                 push;

  // Classify the incoming byte
  always_comb begin
    cls.lc    = in_word.char_code;
    if (in_word.char_code inside {[8'h41:8'h5A]}) begin
      cls.lc = in_word.char_code + 8'd32;
    end
    cls.blank = in_word.char_code inside {8'h20, 8'h09, 8'h0D, 8'h0A};
    cls.digit = in_word.char_code inside {[8'h30:8'h39]};
    cls.dval  = in_word.char_code[3:0];
    cls.minus = in_word.char_code == 8'h2D;
    cls.plus  = in_word.char_code == 8'h2B;
    cls.last  = in_word.last_char;
    cls.empty = in_word.empty_cell;
  end

  assign in_stall = count_r == CNT_W'(QUEUE_DEPTH);
  assign push     = in_valid && !in_stall;
  assign q_valid  = count_r != '0;
  assign q_item   = mem_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/tfp_back.sv @@
module tfp_back import tfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] field_type,
  input  logic       trim_enable,
  input  logic       q_valid,
  input  tfp_cls_t   q_item,
  output logic       q_pop,
  output logic       done_valid,
  output tfp_cell_t  done_cell,
  input  logic       done_ready
);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  tfp_cell_t  cell_r, cell_nxt;
  logic       done_valid_r, done_valid_nxt;
  tfp_cell_t  done_cell_r, done_cell_nxt;
  tfp_cell_t  n;
  logic [63:0] prod;
  logic [2:0]  pos;
  logic        ends_cell;

  assign ends_cell = q_item.last || q_item.empty;
  assign q_pop     = q_valid && (!ends_cell || !done_valid_r || done_ready);
  assign pos       = cell_r.len;
  assign prod      = {cell_r.acc[60:0], 3'b000} + {cell_r.acc[62:0], 1'b0}
                     + {60'd0, q_item.dval};

  // Update the cell state with one word
  always_comb begin
    n         = cell_r;
    phase_nxt = phase_r;
    if (trim_enable && q_item.blank) begin
      if (phase_r == PH_BODY) begin
        phase_nxt = PH_TAIL;
      end
    end else if (phase_r == PH_TAIL) begin
      n.failed = 1'b1;
    end else begin
      phase_nxt = PH_BODY;
      case (field_type)
        FT_INT32, FT_INT64: begin
          if (pos == 3'd0 && q_item.minus) begin
            n.negative = 1'b1;
          end else if (pos == 3'd0 && q_item.plus) begin
            n.negative = cell_r.negative;
          end else if (!q_item.digit) begin
            n.failed = 1'b1;
          end else begin
            n.digit_seen = 1'b1;
            if (!cell_r.failed) begin
              if (field_type == FT_INT64) begin
                if (cell_r.acc > LIMIT64_D10) begin
                  n.failed = 1'b1;
                end else begin
                  n.acc = prod;
                  if (prod > LIMIT64) n.failed = 1'b1;
                end
              end else begin
                n.acc = prod;
                if (prod > LIMIT32) n.failed = 1'b1;
              end
            end
          end
        end
        FT_BOOL: begin
          if (pos == 3'd0) begin
            n.digit_seen = q_item.lc == 8'h30 || q_item.lc == 8'h31;
            n.bit_value  = q_item.lc == 8'h31;
          end
          if (pos >= 3'd4 || true_char(pos[1:0]) != q_item.lc) n.true_match = 1'b0;
          if (pos >= 3'd5 || false_char(pos) != q_item.lc) n.false_match = 1'b0;
        end
        default: begin
          n.failed = cell_r.failed;
        end
      endcase
      if (cell_r.len < LEN_SAT) n.len = cell_r.len + 3'd1;
    end
  end

  // Route the cell to the done stage at its end
  always_comb begin
    cell_nxt       = cell_r;
    done_valid_nxt = done_valid_r && !done_ready;
    done_cell_nxt  = done_cell_r;
    if (q_pop) begin
      if (q_item.empty) begin
        cell_nxt              = CELL_CLEAR;
        done_valid_nxt        = 1'b1;
        done_cell_nxt         = CELL_CLEAR;
        done_cell_nxt.failed  = 1'b1;
      end else if (q_item.last) begin
        cell_nxt       = CELL_CLEAR;
        done_valid_nxt = 1'b1;
        done_cell_nxt  = n;
      end else begin
        cell_nxt = n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      cell_r       <= CELL_CLEAR;
      done_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= ends_cell ? PH_LEAD : phase_nxt;
      end
      cell_r       <= cell_nxt;
      done_valid_r <= done_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    done_cell_r <= done_cell_nxt;
  end

  assign done_valid = done_valid_r;
  assign done_cell  = done_cell_r;

endmodule

@@ rtl/tfp_finish.sv @@
module tfp_finish import tfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] field_type,
  input  logic       done_valid,
  input  tfp_cell_t  done_cell,
  output logic       done_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output tfp_out_t   out_word
);

  logic     out_valid_r;
  tfp_out_t out_word_r, out_word_nxt;

  assign done_ready = !out_valid_r || !out_stall;

  // Decide the typed result of a finished cell
  always_comb begin
    out_word_nxt.value    = '0;
    out_word_nxt.is_valid = 1'b0;
    if (!done_cell.failed && done_cell.len != 3'd0) begin
      case (field_type)
        FT_INT32, FT_INT64: begin
          if (done_cell.digit_seen) begin
            if (done_cell.negative) begin
              out_word_nxt.value    = 64'd0 - done_cell.acc;
              out_word_nxt.is_valid = 1'b1;
            end else if (done_cell.acc <= ((field_type == FT_INT32) ? MAX32 : MAX64)) begin
              out_word_nxt.value    = done_cell.acc;
              out_word_nxt.is_valid = 1'b1;
            end
          end
        end
        FT_BOOL: begin
          if (done_cell.len == 3'd1 && done_cell.digit_seen) begin
            out_word_nxt.value    = {63'd0, done_cell.bit_value};
            out_word_nxt.is_valid = 1'b1;
          end else if (done_cell.len == 3'd4 && done_cell.true_match) begin
            out_word_nxt.value    = 64'd1;
            out_word_nxt.is_valid = 1'b1;
          end else if (done_cell.len == 3'd5 && done_cell.false_match) begin
            out_word_nxt.is_valid = 1'b1;
          end
        end
        default: begin
          out_word_nxt.is_valid = 1'b0;
        end
      endcase
    end
  end

  // Load the output register, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_ready) begin
      out_valid_r <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/typed_text_field_parser.sv @@
// Channel   Direction  Handshake               Word
// in_       input      in_valid / in_stall     char_code, last_char, empty_cell
// out_      output     out_valid / out_stall   value, is_valid
// cfg_      input      cfg_wr_en               cfg_index, cfg_wr_data
//
// One byte is taken per cycle while in_stall is low; the cell state update (one
// shift-add by ten and a 64-bit compare) sets that figure. The word ending a
// cell is registered in the queue, the done stage (cell update) and the output
// register (typed decision). Reset clears the configuration to int32 with
// trimming on, the queue and the working cell. in_stall rises only when the
// queue of QUEUE_DEPTH words is full.
module typed_text_field_parser import tfp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tfp_in_t               in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tfp_out_t              out_word,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  logic [1:0] field_type_r;
  logic       trim_enable_r;
  logic       q_valid;
  tfp_cls_t   q_item;
  logic       q_pop;
  logic       done_valid;
  tfp_cell_t  done_cell;
  logic       done_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_type_r  <= FT_INT32;
      trim_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FIELD_TYPE: field_type_r  <= cfg_wr_data[1:0];
        CFG_TRIM:       trim_enable_r <= cfg_wr_data[0];
        default:        field_type_r  <= field_type_r;
      endcase
    end
  end

  tfp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .field_type  (field_type_r),
    .trim_enable (trim_enable_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .done_valid  (done_valid),
    .done_cell   (done_cell),
    .done_ready  (done_ready)
  );

  tfp_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .field_type (field_type_r),
    .done_valid (done_valid),
    .done_cell  (done_cell),
    .done_ready (done_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  // An invalid cell always reports a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.is_valid |-> out_word.value == 64'd0)
    else $error("invalid result with nonzero value");

  // Boolean results are zero or one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && field_type_r == FT_BOOL |-> out_word.value[63:1] == '0)
    else $error("boolean result out of range");

  // A finished cell waiting on the output register is held
  assert property (@(posedge clk) disable iff (!rst_n)
    done_valid && !done_ready |=> done_valid && $stable(done_cell))
    else $error("finished cell lost while output stalled");

  // A cell end is never taken from the queue while the done stage is blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (q_item.last || q_item.empty) |-> !done_valid || done_ready)
    else $error("cell end popped into a blocked done stage");

endmodule
